@@ design/wrfp_pkg.sv @@
// wrfp_pkg: shared types, codes and constants of the 802.15.4 receive frame parser
// used by every module of the block; depends on nothing else
`timescale 1ns / 1ps
`default_nettype none

package wrfp_pkg;

  // frame layout and limits
  localparam int HDR_BYTES   = 9;
  localparam int FCS_BYTES   = 2;
  localparam int LEN_MIN     = 12;
  localparam int LEN_MAX     = 127;
  localparam int MAX_PAYLOAD = 116;

  // statistics widths
  localparam int COUNT_WIDTH = 32;
  localparam int NUM_W       = COUNT_WIDTH + 8;
  localparam int QUOT_BITS   = 8;
  localparam int QCNT_W      = $clog2(QUOT_BITS);

  // rssi conversion: dbm = -DBM_BASE + raw/3, raw/3 as (raw*DIV3_MUL) >> DIV3_SHIFT
  localparam int DBM_BASE   = 90;
  localparam int DIV3_MUL   = 171;
  localparam int DIV3_SHIFT = 9;

  // input opcodes
  localparam logic [1:0] OP_BYTE  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
  localparam logic [1:0] KIND_ACCEPTED = 2'd1;
  localparam logic [1:0] KIND_REJECTED = 2'd2;
  localparam logic [1:0] KIND_CLEARED  = 2'd3;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [7:0]        payload_byte;
    logic              last_payload;
    logic [7:0]        link_quality;
    logic signed [7:0] signal_dbm;
    logic [7:0]        quality_mean;
    logic signed [7:0] signal_mean;
    logic [31:0]       frames_counted;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic pop;
    logic mul;
    logic div;
    logic fin;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic summary;
    logic res_valid;
    logic div_last;
  } stat_t;

endpackage

`default_nettype wire

@@ design/wrfp_ctrl.sv @@
// wrfp_ctrl: sequencing state machine of the frame parser
// depends on wrfp_pkg for the command and status structs
`timescale 1ns / 1ps
`default_nettype none

module wrfp_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           item_valid,
  output logic                item_ready,
  input  wire logic           result_ready,
  input  wire wrfp_pkg::stat_t stat,
  output wrfp_pkg::cmd_t      cmd
);
  import wrfp_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // take an item only when idle and the result slot is free or being emptied
  assign item_ready = (state == S_IDLE) && (!stat.res_valid || result_ready);

  always_comb begin
    cmd        = '0;
    cmd.accept = item_valid && item_ready;
    cmd.pop    = stat.res_valid && result_ready;
    cmd.mul    = (state == S_MUL);
    cmd.div    = (state == S_DIV);
    cmd.fin    = (state == S_FIN);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.accept && stat.summary) state_next = S_MUL;
      end
      S_MUL: state_next = S_DIV;
      S_DIV: begin
        if (stat.div_last) state_next = S_FIN;
      end
      S_FIN: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

@@ design/wrfp_datapath.sv @@
// wrfp_datapath: frame tracking, statistics registers, mean divider and result register
// depends on wrfp_pkg for types and constants
`timescale 1ns / 1ps
`default_nettype none

module wrfp_datapath (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire wrfp_pkg::item_t item,
  input  wire wrfp_pkg::cmd_t  cmd,
  output wrfp_pkg::stat_t     stat,
  output logic                result_valid,
  output wrfp_pkg::result_t   result
);
  import wrfp_pkg::*;

  // frame and statistics state
  logic [7:0]             byte_position;
  logic [6:0]             frame_length;
  logic                   frame_active;
  logic [7:0]             latched_quality;
  logic [7:0]             quality_average;
  logic signed [7:0]      signal_average;
  logic [COUNT_WIDTH-1:0] accepted_count;

  // summary working registers
  logic signed [7:0]      dbm;
  logic [6:0]             dbm_mag;
  logic [NUM_W-1:0]       q_rem;
  logic [NUM_W-1:0]       s_rem;
  logic [NUM_W-1:0]       div_sub;
  logic [QUOT_BITS-1:0]   q_quot;
  logic [QUOT_BITS-1:0]   s_quot;
  logic [QCNT_W-1:0]      div_cnt;

  // item decode
  logic [7:0]  pay_len;
  logic        len_bad;
  logic [7:0]  pay_end;
  logic [7:0]  lqi_pos;
  logic [7:0]  rssi_pos;
  logic        is_data;
  logic        in_payload;
  logic        is_lqi;
  logic        is_rssi;
  logic        emits;

  assign pay_len  = item.rx_byte - 8'(HDR_BYTES + FCS_BYTES);
  assign len_bad  = (item.rx_byte < 8'(LEN_MIN)) || (item.rx_byte > 8'(LEN_MAX))
                 || (pay_len > 8'(MAX_PAYLOAD));
  assign pay_end  = 8'(HDR_BYTES) + {1'b0, frame_length};
  assign lqi_pos  = pay_end + 8'(FCS_BYTES);
  assign rssi_pos = lqi_pos + 8'd1;

  assign is_data    = (item.opcode == OP_BYTE) && frame_active;
  assign in_payload = is_data && (byte_position >= 8'(HDR_BYTES)) && (byte_position < pay_end);
  assign is_lqi     = is_data && (byte_position == lqi_pos);
  assign is_rssi    = is_data && (byte_position == rssi_pos);
  assign emits      = (item.opcode == OP_CLEAR) || ((item.opcode == OP_START) && len_bad)
                   || in_payload;

  // raw rssi divided by three
  logic [15:0] div3_prod;
  logic [6:0]  div3;
  assign div3_prod = 16'(item.rx_byte) * 16'(DIV3_MUL);
  assign div3      = div3_prod[DIV3_SHIFT+6:DIV3_SHIFT];

  // weighted sums for the new means: mean*(n-1) + sample
  logic [COUNT_WIDTH-1:0] cnt_less;
  logic [7:0]             sa_mag;
  logic [NUM_W-1:0]       q_prod;
  logic [NUM_W-1:0]       s_prod;
  assign cnt_less = accepted_count - {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
  assign sa_mag   = 8'(-signal_average);
  assign q_prod   = NUM_W'(quality_average) * NUM_W'(cnt_less);
  assign s_prod   = NUM_W'(sa_mag) * NUM_W'(cnt_less);

  // one restoring step per cycle on both numerators
  logic q_ge;
  logic s_ge;
  assign q_ge = (q_rem >= div_sub);
  assign s_ge = (s_rem >= div_sub);

  assign stat.summary   = is_rssi;
  assign stat.res_valid = result_valid;
  assign stat.div_last  = (div_cnt == '0);

  // frame tracking and statistics
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      frame_length    <= '0;
      frame_active    <= 1'b0;
      latched_quality <= '0;
      quality_average <= '0;
      signal_average  <= '0;
      accepted_count  <= '0;
    end else if (cmd.accept) begin
      case (item.opcode)
        OP_CLEAR: begin
          quality_average <= '0;
          signal_average  <= '0;
          accepted_count  <= '0;
        end
        OP_START: begin
          byte_position <= '0;
          frame_active  <= !len_bad;
          if (!len_bad) frame_length <= pay_len[6:0];
        end
        OP_BYTE: begin
          if (frame_active) begin
            if (is_lqi) latched_quality <= item.rx_byte;
            if (is_rssi) begin
              frame_active  <= 1'b0;
              byte_position <= '0;
              if (accepted_count != '1)
                accepted_count <= accepted_count + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
            end else begin
              byte_position <= byte_position + 8'd1;
            end
          end
        end
        default: ;
      endcase
    end else if (cmd.fin) begin
      quality_average <= q_quot;
      signal_average  <= 8'd0 - s_quot;
    end
  end

  // mean divider: convert rssi on the RSSI byte, load sums, then eight quotient bits
  always_ff @(posedge clk) begin
    if (cmd.accept && is_rssi) begin
      dbm     <= 8'(-DBM_BASE) + {1'b0, div3};
      dbm_mag <= 7'(DBM_BASE) - div3;
    end
    if (cmd.mul) begin
      q_rem   <= q_prod + NUM_W'(latched_quality);
      s_rem   <= s_prod + NUM_W'(dbm_mag);
      div_sub <= NUM_W'(accepted_count) << (QUOT_BITS - 1);
      div_cnt <= QCNT_W'(QUOT_BITS - 1);
      q_quot  <= '0;
      s_quot  <= '0;
    end else if (cmd.div) begin
      if (q_ge) q_rem <= q_rem - div_sub;
      if (s_ge) s_rem <= s_rem - div_sub;
      q_quot  <= {q_quot[QUOT_BITS-2:0], q_ge};
      s_quot  <= {s_quot[QUOT_BITS-2:0], s_ge};
      div_sub <= div_sub >> 1;
      div_cnt <= div_cnt - QCNT_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if ((cmd.accept && emits) || cmd.fin) begin
      result_valid <= 1'b1;
    end else if (cmd.pop) begin
      result_valid <= 1'b0;
    end
  end

  // result contents: summary at write-back, otherwise from the accepted item
  result_t result_next;
  always_comb begin
    result_next = '0;
    if (cmd.fin) begin
      result_next.kind           = KIND_ACCEPTED;
      result_next.link_quality   = latched_quality;
      result_next.signal_dbm     = dbm;
      result_next.quality_mean   = q_quot;
      result_next.signal_mean    = 8'd0 - s_quot;
      result_next.frames_counted = 32'(accepted_count);
    end else begin
      case (item.opcode)
        OP_CLEAR: result_next.kind = KIND_CLEARED;
        OP_START: result_next.kind = KIND_REJECTED;
        default: begin
          result_next.kind         = KIND_PAYLOAD;
          result_next.payload_byte = item.rx_byte;
          result_next.last_payload = (byte_position + 8'd1 == pay_end);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((cmd.accept && emits) || cmd.fin) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

@@ design/wpan_rx_frame_parser_link_stats_core.sv @@
// wpan_rx_frame_parser_link_stats_core: top level of the receive frame parser
// with link statistics. Input channel item (opcode, rx_byte) and output
// channel result, both valid/ready; one transaction moves one packed struct.
// Length byte (opcode start) opens a frame; header, FCS and LQI bytes
// are consumed silently, payload bytes come out one per byte,
// and the RSSI byte closes the frame with an accepted-frame summary.
// Results: payload, reject and clear results are valid the cycle after the
// input transaction. The summary follows the RSSI byte through S_MUL, which
// forms mean*(n-1)+sample, S_DIV, which runs the restoring divider (one
// quotient bit per step for both means), and S_FIN, which writes back the means.
// Throughput: one byte per cycle while the output register is free or being
// taken, except the RSSI byte, which holds item_ready low while the divider runs.
// Stall: a waiting result sits in the output register; item_ready stays high
// only if that register is empty or being taken in the same cycle.
// Reset (rst, synchronous): parser idle, means and frame count zero, no result.
// Depends on wrfp_pkg, wrfp_ctrl and wrfp_datapath.
`timescale 1ns / 1ps
`default_nettype none

module wpan_rx_frame_parser_link_stats_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           item_valid,
  output logic                item_ready,
  input  wire wrfp_pkg::item_t item,
  output logic                result_valid,
  input  wire logic           result_ready,
  output wrfp_pkg::result_t   result
);
  import wrfp_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // controller
  wrfp_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_ready (result_ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  // datapath
  wrfp_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .stat         (stat),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

`default_nettype wire

@@ design/wrfp_checker.sv @@
// wrfp_checker: port-level assertions on the frame parser top level, with its bind
// depends on wrfp_pkg and wpan_rx_frame_parser_link_stats_core
`timescale 1ns / 1ps
`default_nettype none

module wrfp_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              item_valid,
  input wire logic              item_ready,
  input wire wrfp_pkg::item_t   item,
  input wire logic              result_valid,
  input wire logic              result_ready,
  input wire wrfp_pkg::result_t result
);
  import wrfp_pkg::*;

  // a waiting result holds until taken
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed or dropped while stalled");

  // a clear transaction is answered in the next cycle
  a_clear_answer: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item.opcode == OP_CLEAR
    |=> result_valid && result.kind == KIND_CLEARED)
    else $error("clear transaction not answered");

  // a short length byte is rejected in the next cycle
  a_short_reject: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item.opcode == OP_START && item.rx_byte < 8'(LEN_MIN)
    |=> result_valid && result.kind == KIND_REJECTED)
    else $error("short length byte not rejected");

  // summaries report a counted frame and a non-positive mean
  a_summary_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.kind == KIND_ACCEPTED
    |-> result.frames_counted != 32'd0 && (result.signal_mean[7] || result.signal_mean == 8'sd0))
    else $error("summary fields out of range");

endmodule

bind wpan_rx_frame_parser_link_stats_core wrfp_checker u_wrfp_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .item         (item),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

`default_nettype wire

@@ tb/wpan_rx_frame_parser_link_stats_core_tb.sv @@
// wpan_rx_frame_parser_link_stats_core_tb: self-checking testbench of the receive frame parser
// directed stimulus table, then random receive-buffer streams checked against a built-in parser
// depends on wrfp_pkg and wpan_rx_frame_parser_link_stats_core
`timescale 1ns / 1ps

module wpan_rx_frame_parser_link_stats_core_tb;
  import wrfp_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 1400;
  localparam int HOLD_START   = 1500;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 30;
  localparam int MAX_PRINTS   = 40;

  // how a stimulus row is checked
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_GIVEN
  } check_t;

  typedef struct packed {
    check_t  check;
    item_t   data;
    result_t want;
  } row_t;

  localparam result_t RES_NONE     = '0;
  localparam result_t RES_CLEARED  = {KIND_CLEARED, 73'd0};
  localparam result_t RES_REJECTED = {KIND_REJECTED, 73'd0};
  // first frame after a clear: lqi 255, raw rssi 255 -> -5 dBm, means equal the sample
  localparam result_t RES_FIRST_SUMMARY =
    {KIND_ACCEPTED, 8'd0, 1'b0, 8'hFF, -8'sd5, 8'hFF, -8'sd5, 32'd1};

  logic    clk          = 1'b0;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  logic    item_ready;
  item_t   item         = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  // parser state as the block should hold it
  logic [7:0]        rx_pos      = '0;
  logic [6:0]        rx_paylen   = '0;
  logic              in_frame    = 1'b0;
  logic [7:0]        held_lqi    = '0;
  logic [7:0]        lqi_mean    = '0;
  logic signed [7:0] dbm_mean    = '0;
  logic [31:0]       frame_count = '0;

  result_t pending_results[$];
  row_t    buffer_stream[$];
  row_t    directed_table[$];

  int mismatches    = 0;
  int results_seen  = 0;
  int items_sent    = 0;
  int random_items  = 0;
  int send_calm     = 0;
  int frames_ok     = 0;
  int payload_total = 0;
  int rejects_seen  = 0;
  int clears_seen   = 0;
  int longest_frame = 0;

  wpan_rx_frame_parser_link_stats_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #5 clk = ~clk;

  // run limit
  initial begin
    #(64'd10_000_000);
    $display("TEST FAILED");
    $finish;
  end

  // next result of the parser for one accepted byte; updates the parser state
  function automatic bit parse_step(input item_t it, output result_t r);
    int     p;
    int     pay_end;
    int     lqi_pos;
    int     dbm;
    longint n;
    r = '0;
    if (it.opcode == OP_CLEAR) begin
      lqi_mean    = '0;
      dbm_mean    = '0;
      frame_count = '0;
      r.kind      = KIND_CLEARED;
      clears_seen++;
      return 1'b1;
    end
    if (it.opcode == OP_START) begin
      in_frame = 1'b0;
      rx_pos   = '0;
      if (it.rx_byte < LEN_MIN || it.rx_byte > LEN_MAX ||
          int'(it.rx_byte) - HDR_BYTES - FCS_BYTES > MAX_PAYLOAD) begin
        r.kind = KIND_REJECTED;
        rejects_seen++;
        return 1'b1;
      end
      rx_paylen = 7'(int'(it.rx_byte) - HDR_BYTES - FCS_BYTES);
      in_frame  = 1'b1;
      return 1'b0;
    end
    if (it.opcode != OP_BYTE || !in_frame)
      return 1'b0;

    p       = int'(rx_pos);
    pay_end = HDR_BYTES + int'(rx_paylen);
    lqi_pos = pay_end + FCS_BYTES;
    rx_pos  = rx_pos + 8'd1;
    // payload bytes pass straight through
    if (p >= HDR_BYTES && p < pay_end) begin
      r.kind         = KIND_PAYLOAD;
      r.payload_byte = it.rx_byte;
      r.last_payload = (p + 1 == pay_end);
      payload_total++;
      return 1'b1;
    end
    if (p == lqi_pos) begin
      held_lqi = it.rx_byte;
    end else if (p == lqi_pos + 1) begin
      // rssi byte closes the frame: convert, count, update the means
      dbm = int'(it.rx_byte / 8'd3) - DBM_BASE;
      if (frame_count != '1)
        frame_count++;
      n        = longint'(frame_count);
      lqi_mean = 8'((longint'(lqi_mean) * (n - 1) + longint'(held_lqi)) / n);
      dbm_mean = 8'((longint'(dbm_mean) * (n - 1) + longint'(dbm)) / n);
      in_frame = 1'b0;
      rx_pos   = '0;
      r.kind           = KIND_ACCEPTED;
      r.link_quality   = held_lqi;
      r.signal_dbm     = 8'(dbm);
      r.quality_mean   = lqi_mean;
      r.signal_mean    = dbm_mean;
      r.frames_counted = frame_count;
      frames_ok++;
      if (int'(rx_paylen) > longest_frame)
        longest_frame = int'(rx_paylen);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic row_t row(check_t c, logic [1:0] op, logic [7:0] b, result_t want);
    row_t r;
    r.check = c;
    r.data  = {op, b};
    r.want  = want;
    return r;
  endfunction

  // gap length: mostly none or short, a few long, now and then a calm stretch
  function automatic int idle_len(inout int calm);
    int pick;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      calm = $urandom_range(30, 120);
      return 0;
    end
    if (pick < 60)
      return 0;
    if (pick < 88)
      return $urandom_range(1, 3);
    if (pick < 98)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("[%0t] result %0d: %s", $time, results_seen, msg);
  endtask

  // offer one byte, wait for its transaction, then log what it should cause
  task automatic send_row(row_t r);
    int      gap;
    bit      emits;
    result_t want;
    gap = idle_len(send_calm);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= r.data;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    emits = parse_step(r.data, want);
    if (r.check == CHK_NONE) begin
      emits = 1'b0;
    end else if (r.check == CHK_GIVEN) begin
      emits = 1'b1;
      want  = r.want;
    end
    if (emits)
      pending_results.push_back(want);
    items_sent++;
  endtask

  task automatic queue_byte(logic [1:0] op, logic [7:0] b, bit counted);
    buffer_stream.push_back(row(CHK_MODEL, op, b, RES_NONE));
    if (counted)
      random_items++;
  endtask

  // length byte plus up to keep buffer bytes of a frame, sometimes with a clear inside
  task automatic queue_frame(int len, int keep);
    int         total;
    int         clear_at;
    logic [7:0] b;
    total    = len + 2;
    clear_at = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, total - 1)) : -1;
    queue_byte(OP_START, 8'(len), 1'b1);
    for (int i = 0; i < total && i < keep; i++) begin
      if (i == clear_at)
        queue_byte(OP_CLEAR, 8'($urandom), 1'b1);
      b = 8'($urandom);
      // lqi and rssi extremes
      if (i >= total - 2 && $urandom_range(0, 3) == 0)
        b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      queue_byte(OP_BYTE, b, 1'b1);
    end
  endtask

  task automatic check_result(result_t got);
    result_t want;
    results_seen++;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result of kind %0d", got.kind));
      return;
    end
    want = pending_results.pop_front();
    if (got.kind !== want.kind)
      report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
    if (got.payload_byte !== want.payload_byte)
      report_mismatch($sformatf("payload_byte %0h, want %0h",
                                got.payload_byte, want.payload_byte));
    if (got.last_payload !== want.last_payload)
      report_mismatch($sformatf("last_payload %0b, want %0b",
                                got.last_payload, want.last_payload));
    if (got.link_quality !== want.link_quality)
      report_mismatch($sformatf("link_quality %0d, want %0d",
                                got.link_quality, want.link_quality));
    if (got.signal_dbm !== want.signal_dbm)
      report_mismatch($sformatf("signal_dbm %0d, want %0d", got.signal_dbm, want.signal_dbm));
    if (got.quality_mean !== want.quality_mean)
      report_mismatch($sformatf("quality_mean %0d, want %0d",
                                got.quality_mean, want.quality_mean));
    if (got.signal_mean !== want.signal_mean)
      report_mismatch($sformatf("signal_mean %0d, want %0d",
                                got.signal_mean, want.signal_mean));
    if (got.frames_counted !== want.frames_counted)
      report_mismatch($sformatf("frames_counted %0d, want %0d",
                                got.frames_counted, want.frames_counted));
  endtask

  // result side: compare every transaction with the oldest expectation
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready)
      check_result(result);
  end

  // receiver: random back-pressure plus one long hold-off
  initial begin : result_sink
    int on_len;
    int off_len;
    int cyc;
    int calm;
    bit held;
    cyc  = 0;
    calm = 0;
    held = 1'b0;
    forever begin
      if (!held && cyc >= HOLD_START) begin
        // sender keeps offering, so the block fills and stalls its input
        held = 1'b1;
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        cyc += HOLD_CYCLES;
      end
      off_len = idle_len(calm);
      if (off_len > 0) begin
        result_ready <= 1'b0;
        repeat (off_len) @(posedge clk);
        cyc += off_len;
      end
      on_len = $urandom_range(1, 8);
      result_ready <= 1'b1;
      repeat (on_len) @(posedge clk);
      cyc += on_len;
    end
  end

  // sender: reset, directed table, random streams, drain, verdict
  initial begin
    int pick;
    int len;
    directed_table = '{
      row(CHK_GIVEN, OP_CLEAR,  8'h00,  RES_CLEARED),
      row(CHK_NONE,  OP_UNUSED, 8'hFF,  RES_NONE),
      row(CHK_NONE,  OP_BYTE,   8'h5A,  RES_NONE),
      // length bytes outside the legal range
      row(CHK_GIVEN, OP_START,  8'd0,   RES_REJECTED),
      row(CHK_GIVEN, OP_START,  8'd11,  RES_REJECTED),
      row(CHK_GIVEN, OP_START,  8'd128, RES_REJECTED),
      row(CHK_GIVEN, OP_START,  8'd255, RES_REJECTED),
      // shortest frame, with a statistics clear among the header bytes
      row(CHK_NONE,  OP_START,  8'd12,  RES_NONE),
      row(CHK_NONE,  OP_BYTE,   8'hFF,  RES_NONE),
      row(CHK_NONE,  OP_BYTE,   8'h00,  RES_NONE),
      row(CHK_NONE,  OP_BYTE,   8'hFF,  RES_NONE),
      row(CHK_NONE,  OP_BYTE,   8'h00,  RES_NONE),
      row(CHK_GIVEN, OP_CLEAR,  8'hFF,  RES_CLEARED),
      row(CHK_NONE,  OP_BYTE,   8'hFF,  RES_NONE),
      row(CHK_NONE,  OP_BYTE,   8'h00,  RES_NONE),
      row(CHK_NONE,  OP_BYTE,   8'hFF,  RES_NONE),
      row(CHK_NONE,  OP_BYTE,   8'h00,  RES_NONE),
      row(CHK_NONE,  OP_BYTE,   8'hFF,  RES_NONE),
      row(CHK_GIVEN, OP_BYTE,   8'hA5,  {KIND_PAYLOAD, 8'hA5, 1'b1, 64'd0}),
      row(CHK_NONE,  OP_BYTE,   8'h00,  RES_NONE),
      row(CHK_NONE,  OP_BYTE,   8'hFF,  RES_NONE),
      row(CHK_NONE,  OP_BYTE,   8'hFF,  RES_NONE),
      row(CHK_GIVEN, OP_BYTE,   8'hFF,  RES_FIRST_SUMMARY),
      // a new length byte abandons the frame in progress
      row(CHK_MODEL, OP_START,  8'd20,  RES_NONE),
      row(CHK_MODEL, OP_BYTE,   8'h33,  RES_NONE),
      row(CHK_MODEL, OP_START,  8'd127, RES_NONE)
    };

    // random part: mostly whole frames, the rest broken frames, bad length bytes, clears and noise
    while (random_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      len  = $urandom_range(LEN_MIN, 30);
      if (pick % 10 == 0)
        len = $urandom_range(31, LEN_MAX - 1);
      else if (pick % 20 == 1)
        len = LEN_MIN;
      else if (pick % 20 == 11)
        len = LEN_MAX;
      if (pick < 72)
        queue_frame(len, len + 2);
      else if (pick < 82)
        queue_frame(len, $urandom_range(0, 20));
      else if (pick < 88)
        queue_byte(OP_START, $urandom_range(0, 1) ? 8'($urandom_range(0, LEN_MIN - 1)) :
                                                    8'($urandom_range(LEN_MAX + 1, 255)), 1'b1);
      else if (pick < 92)
        queue_byte(OP_CLEAR, 8'($urandom), 1'b1);
      else if (pick < 97)
        repeat ($urandom_range(1, 4)) queue_byte(OP_BYTE, 8'($urandom), 1'b0);
      else
        queue_byte(OP_UNUSED, 8'($urandom), 1'b0);
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_table[i])
      send_row(directed_table[i]);
    foreach (buffer_stream[i])
      send_row(buffer_stream[i]);
    item_valid <= 1'b0;

    // drain, then give the block time to show any stray result
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d input transactions: %0d frames accepted (longest payload %0d bytes),",
             items_sent, frames_ok, longest_frame);
    $display("%0d payload bytes, %0d bad length bytes, %0d clears, %0d results checked",
             payload_total, rejects_seen, clears_seen, results_seen);
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
design/wrfp_pkg.sv
design/wrfp_ctrl.sv
design/wrfp_datapath.sv
design/wpan_rx_frame_parser_link_stats_core.sv
design/wrfp_checker.sv
tb/wpan_rx_frame_parser_link_stats_core_tb.sv
